FILE: rtl/bayer_dead_pixel_correction_assert.svh
`ifndef BAYER_DEAD_PIXEL_CORRECTION_ASSERT_SVH
`define BAYER_DEAD_PIXEL_CORRECTION_ASSERT_SVH
// Plain property, sampled on clk, off during reset.
`define BDPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Implication, same clock and reset.
`define BDPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

FILE: rtl/bdpc_pkg.sv
package bdpc_pkg;
	localparam int IN_BITS     = 16;
	localparam int WIDTH_BITS  = 13;
	localparam int HEIGHT_BITS = 15;
	localparam int GAIN_BITS   = 12;
	localparam int GAIN_FRAC   = 8;
	localparam int CFG_IDX_BITS = 8;
	localparam int CFG_DATA_BITS = 16;
	localparam int FIFO_DEPTH  = 4;
	localparam int ROW_BITS    = HEIGHT_BITS + 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 8'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT = 8'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DARK   = 8'd3;

	typedef struct packed {
		logic [IN_BITS-1:0] pixel_value;
		logic               flush;
	} px_t;

	typedef struct packed {
		logic [IN_BITS-1:0] corrected_value;
		logic               was_replaced;
		logic               frame_end;
	} res_t;

	// per-column job info from the front to the back
	typedef struct packed {
		logic emit;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic frame_end;
	} job_t;
endpackage

FILE: rtl/bayer_dead_pixel_correction.sv
// Dead pixel correction on a raw Bayer stream, 3x3 same-color median.
// px channel: one raw sample per item in raster order (valid/stall). Items
// with flush set carry no pixel; after the last pixel of a frame send
// 2*W+2 of them so the last two rows and two pixels come out. A flush item
// inside a frame is dropped.
// res channel: one result per pixel, in raster order, frame_end on the last.
// cfg channel: index/data writes, always ready. Width or height writes
// restart the frame; write only while the block is idle.
// A pixel's result is produced by the item that arrives 2*W+2 items after
// it; that item passes the front register, the queue and a six-stage
// median/threshold pipe before res_valid rises.
// Throughput: one item per cycle while px_stall is low; the line store is one
// RAM with one read and one write port, one column access per item.
// Reset: counters clear, registers return to 4096x4096, gains 1.5 / 0.75,
// no clearing pass. A stall on res freezes the back end; the queue then
// fills and px_stall rises.
module bayer_dead_pixel_correction
	import bdpc_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int PIXEL_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     px_valid,
	output logic                     px_stall,
	input  px_t                      px_data,
	output logic                     res_valid,
	input  logic                     res_stall,
	output res_t                     res_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int FW = $clog2(FIFO_DEPTH+1);
	localparam int EW = 3*PIXEL_BITS + $bits(job_t);

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q, h_eff;
	logic [GAIN_BITS-1:0]   bright_q, dark_q;
	logic [WW-1:0]          w_eff;
	logic                   cfg_we, restart;
	logic                   push, pop, empty;
	logic [FW-1:0]          fifo_count;
	logic [3*PIXEL_BITS-1:0] push_col, pop_col;
	job_t                   push_job, pop_job;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign restart   = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_BITS'(4096);
			height_q <= HEIGHT_BITS'(4096);
			bright_q <= GAIN_BITS'(384);
			dark_q   <= GAIN_BITS'(192);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_BITS-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
				REG_BRIGHT: bright_q <= cfg_data[GAIN_BITS-1:0];
				REG_DARK:   dark_q   <= cfg_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(width_q) < 2) begin
			w_eff = WW'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff = (height_q < HEIGHT_BITS'(2)) ? HEIGHT_BITS'(2) : height_q;
	end

	bdpc_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.px_valid   (px_valid),
		.px_stall   (px_stall),
		.px_data    (px_data),
		.fifo_count (fifo_count),
		.push       (push),
		.push_col   (push_col),
		.push_job   (push_job)
	);

	bdpc_fifo #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_col, push_job}),
		.pop    (pop),
		.rdata  ({pop_col, pop_job}),
		.empty  (empty),
		.count  (fifo_count)
	);

	bdpc_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.bright_gain (bright_q),
		.dark_gain   (dark_q),
		.empty       (empty),
		.col         (pop_col),
		.job         (pop_job),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data)
	);
endmodule

FILE: rtl/bdpc_ram.sv
module bdpc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/bdpc_fifo.sv
module bdpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [$clog2(DEPTH+1)-1:0] count_q;

	assign rdata = slot_q[rptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: rtl/bdpc_front.sv
module bdpc_front
	import bdpc_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      w_eff,
	input  logic [HEIGHT_BITS-1:0]              h_eff,
	input  logic                                px_valid,
	output logic                                px_stall,
	input  px_t                                 px_data,
	input  logic [$clog2(FIFO_DEPTH+1)-1:0]     fifo_count,
	output logic                                push,
	output logic [3*PIXEL_BITS-1:0]             push_col,
	output job_t                                push_job
);
	localparam int P  = PIXEL_BITS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int DW = $clog2(2*MAX_WIDTH+3);
	localparam int FW = $clog2(FIFO_DEPTH+1);

	logic [CW-1:0]          col_q, ocol_q, col_s1;
	logic [ROW_BITS-1:0]    row_q;
	logic [HEIGHT_BITS-1:0] orow_q;
	logic [DW-1:0]          d_q, lag;
	logic                   valid_s1;
	logic [P-1:0]           pix_s1;
	job_t                   job, job_s1;
	logic [4*P-1:0]         rd;
	logic [WW-1:0]          w_m1;
	logic                   in_frame, accept, take, emit, fend;

	assign w_m1     = w_eff - WW'(1);
	assign lag      = (DW'(w_eff) << 1) + DW'(2);
	assign in_frame = row_q < ROW_BITS'(h_eff);
	assign px_stall = ((FW+1)'(fifo_count) + (FW+1)'(valid_s1)) >= (FW+1)'(FIFO_DEPTH);
	assign accept   = px_valid && !px_stall;
	assign take     = accept && !(in_frame && px_data.flush);
	assign emit     = (d_q == lag);
	assign fend     = emit && (ocol_q == w_m1[CW-1:0]) && (orow_q == h_eff - HEIGHT_BITS'(1));

	always_comb begin
		job.emit      = emit;
		job.top_ok    = ((HEIGHT_BITS+1)'(orow_q) + (HEIGHT_BITS+1)'(2))
			< (HEIGHT_BITS+1)'(h_eff);
		job.bot_ok    = orow_q >= HEIGHT_BITS'(2);
		job.left_ok   = ocol_q >= CW'(2);
		job.right_ok  = ((WW+1)'(ocol_q) + (WW+1)'(2)) < (WW+1)'(w_eff);
		job.frame_end = fend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			d_q      <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (restart) begin
				col_q  <= '0;
				row_q  <= '0;
				d_q    <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else if (take) begin
				if (fend) begin
					col_q  <= '0;
					row_q  <= '0;
					d_q    <= '0;
					ocol_q <= '0;
					orow_q <= '0;
				end else begin
					if (col_q == w_m1[CW-1:0]) begin
						col_q <= '0;
						row_q <= row_q + ROW_BITS'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
					if (emit) begin
						if (ocol_q == w_m1[CW-1:0]) begin
							ocol_q <= '0;
							orow_q <= orow_q + HEIGHT_BITS'(1);
						end else begin
							ocol_q <= ocol_q + CW'(1);
						end
					end else begin
						d_q <= d_q + DW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_s1 <= col_q;
			job_s1 <= job;
			pix_s1 <= (in_frame && !px_data.flush) ? px_data.pixel_value[P-1:0] : '0;
		end
	end

	// one entry per column: rows R-1..R-4, newest in the low lane
	bdpc_ram #(.WIDTH(4*P), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata ({rd[3*P-1:0], pix_s1}),
		.re    (take),
		.raddr (col_q),
		.rdata (rd)
	);

	assign push     = valid_s1;
	assign push_col = {pix_s1, rd[2*P-1:P], rd[4*P-1:3*P]};
	assign push_job = job_s1;
endmodule

FILE: rtl/bdpc_back.sv
module bdpc_back
	import bdpc_pkg::*;
#(
	parameter int PIXEL_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [GAIN_BITS-1:0]    bright_gain,
	input  logic [GAIN_BITS-1:0]    dark_gain,
	input  logic                    empty,
	input  logic [3*PIXEL_BITS-1:0] col,
	input  job_t                    job,
	output logic                    pop,
	output logic                    res_valid,
	input  logic                    res_stall,
	output res_t                    res_data
);
	localparam int P  = PIXEL_BITS;
	localparam int XW = P + GAIN_BITS - GAIN_FRAC;
	localparam logic [XW-1:0] PIXMAX = XW'((1 << P) - 1);

	typedef logic [P-1:0] pix_t;

	function automatic pix_t mn(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction
	function automatic pix_t mx(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction
	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return mx(mn(a, b), mn(mx(a, b), c));
	endfunction

	// window columns: [0] newest, [2] centre, [4] oldest; rows [0] top..[2] bottom
	pix_t win_q [5][3];
	pix_t lo_s2 [3], mi_s2 [3], hi_s2 [3];
	pix_t lo_s3, mi_s3, hi_s3, m_s4, pix_s2, pix_s3, pix_s4, m_s5, pix_s5;
	logic [P+GAIN_BITS-1:0] pb_s5, pd_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic fe_s2, fe_s3, fe_s4, fe_s5;
	job_t job_s1;
	logic adv;
	pix_t sel [3][3];
	logic [XW-1:0] bright, dark, bsh;
	logic repl;

	assign adv = !res_valid || !res_stall;
	assign pop = adv && !empty;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// i: 0 right, 1 centre, 2 left column
			int k;
			k = (i == 0) ? (job_s1.right_ok ? 0 : 2) :
				(i == 2) ? (job_s1.left_ok ? 4 : 2) : 2;
			sel[i][0] = job_s1.top_ok ? win_q[k][0] : win_q[k][1];
			sel[i][1] = win_q[k][1];
			sel[i][2] = job_s1.bot_ok ? win_q[k][2] : win_q[k][1];
		end
	end

	assign bsh    = pb_s5[P+GAIN_BITS-1:GAIN_FRAC];
	assign bright = (bsh > PIXMAX) ? PIXMAX : bsh;
	assign dark   = pd_s5[P+GAIN_BITS-1:GAIN_FRAC];
	assign repl   = (XW'(pix_s5) > bright) || (XW'(pix_s5) < dark);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= !empty && job.emit;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			res_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			win_q[0][0] <= col[3*P-1:2*P];
			win_q[0][1] <= col[2*P-1:P];
			win_q[0][2] <= col[P-1:0];
			for (int i = 1; i < 5; i++) begin
				win_q[i] <= win_q[i-1];
			end
			job_s1 <= job;
		end
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				lo_s2[i] <= mn(mn(sel[i][0], sel[i][1]), sel[i][2]);
				mi_s2[i] <= med3(sel[i][0], sel[i][1], sel[i][2]);
				hi_s2[i] <= mx(mx(sel[i][0], sel[i][1]), sel[i][2]);
			end
			pix_s2 <= win_q[2][1];
			fe_s2  <= job_s1.frame_end;

			lo_s3  <= mx(mx(lo_s2[0], lo_s2[1]), lo_s2[2]);
			mi_s3  <= med3(mi_s2[0], mi_s2[1], mi_s2[2]);
			hi_s3  <= mn(mn(hi_s2[0], hi_s2[1]), hi_s2[2]);
			pix_s3 <= pix_s2;
			fe_s3  <= fe_s2;

			m_s4   <= med3(lo_s3, mi_s3, hi_s3);
			pix_s4 <= pix_s3;
			fe_s4  <= fe_s3;

			pb_s5  <= (P+GAIN_BITS)'(m_s4) * (P+GAIN_BITS)'(bright_gain);
			pd_s5  <= (P+GAIN_BITS)'(m_s4) * (P+GAIN_BITS)'(dark_gain);
			m_s5   <= m_s4;
			pix_s5 <= pix_s4;
			fe_s5  <= fe_s4;

			res_data.corrected_value <= IN_BITS'(repl ? m_s5 : pix_s5);
			res_data.was_replaced    <= repl;
			res_data.frame_end       <= fe_s5;
		end
	end
endmodule

FILE: rtl/bdpc_checker.sv
`include "bayer_dead_pixel_correction_assert.svh"
module bdpc_checker
	import bdpc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic px_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res_data,
	input logic cfg_ready
);
	`BDPC_ASSERT_IMP(a_res_hold, res_valid && res_stall, ##1 (res_valid && $stable(res_data)), "stalled result changed")
	`BDPC_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")
	// the queue only fills up behind a stalled result
	`BDPC_ASSERT_IMP(a_stall_cause, $rose(px_stall), $past(res_valid && res_stall), "input stalled without output back-pressure")
endmodule

bind bayer_dead_pixel_correction bdpc_checker u_bdpc_checker (.*);

FILE: tb/testbench.sv
module testbench;
	import bdpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = 4096;
	localparam int WATCH_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 1950;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic px_valid = 1'b0;
	logic px_stall;
	px_t px_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	bayer_dead_pixel_correction DUT (.*);

	// predictor state
	logic [15:0] raw_rows [6*MAXW];
	int unsigned img_w = 4096, img_h = 4096, gain_hi = 384, gain_lo = 192;
	int unsigned col_pos, row_pos, out_pos;
	res_t expected_pixels [$];

	int errors = 0;
	int items_sent = 0;
	int idle_pct = 38;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	bit hold_armed = 1'b0;
	int hold_cnt = 0;
	int watch = 0;

	initial forever #2 clk = ~clk;

	function automatic int unsigned eff_w();
		return img_w < 2 ? 2 : (img_w > MAXW ? MAXW : img_w);
	endfunction

	function automatic int unsigned eff_h();
		return img_h < 2 ? 2 : img_h;
	endfunction

	function automatic logic [15:0] raw_at(int unsigned r, int unsigned c);
		return raw_rows[(r % 6) * MAXW + (c % MAXW)];
	endfunction

	task automatic correct_pixel(px_t p);
		int unsigned w, h, total, pos, q, r, c, rr, cc, m, pix, br, dk, t;
		int unsigned s [9];
		int n;
		res_t e;
		w = eff_w();
		h = eff_h();
		total = w * h;
		pos = row_pos * w + col_pos;
		if (pos < total) begin
			if (p.flush) return;
			raw_rows[(row_pos % 6) * MAXW + col_pos] = p.pixel_value;
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (pos + 1 < out_pos + 2 * w + 3) return;
		q = out_pos;
		r = q / w;
		c = q % w;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			rr = (i == 0) ? (r >= 2 ? r - 2 : r) : (i == 2) ? (r + 2 < h ? r + 2 : r) : r;
			for (int j = 0; j < 3; j++) begin
				cc = (j == 0) ? (c >= 2 ? c - 2 : c) : (j == 2) ? (c + 2 < w ? c + 2 : c) : c;
				s[n++] = raw_at(rr, cc);
			end
		end
		for (int i = 0; i < 9; i++)
			for (int j = 0; j < 8 - i; j++)
				if (s[j] > s[j+1]) begin
					t = s[j];
					s[j] = s[j+1];
					s[j+1] = t;
				end
		m = s[4];
		pix = raw_at(r, c);
		br = (m * gain_hi) >> 8;
		if (br > 65535) br = 65535;
		dk = (m * gain_lo) >> 8;
		e.was_replaced = (pix > br) || (pix < dk);
		e.corrected_value = e.was_replaced ? m[15:0] : pix[15:0];
		out_pos++;
		e.frame_end = (out_pos >= total);
		if (e.frame_end) begin
			col_pos = 0;
			row_pos = 0;
			out_pos = 0;
		end
		expected_pixels = {expected_pixels, e};
	endtask

	task automatic send_item(logic [15:0] v, logic fl);
		px_t p;
		p.pixel_value = v;
		p.flush = fl;
		while (!quiet && $urandom_range(99) < idle_pct) begin
			px_valid <= 1'b0;
			@(posedge clk);
		end
		px_valid <= 1'b1;
		px_data <= p;
		do @(posedge clk); while (px_stall);
		items_sent++;
		correct_pixel(p);
	endtask

	task automatic settle();
		px_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WIDTH: begin
				img_w = val & 16'h1FFF;
				col_pos = 0; row_pos = 0; out_pos = 0;
			end
			REG_HEIGHT: begin
				img_h = val & 16'h7FFF;
				col_pos = 0; row_pos = 0; out_pos = 0;
			end
			REG_BRIGHT: gain_hi = val & 16'hFFF;
			REG_DARK: gain_lo = val & 16'hFFF;
			default: ;
		endcase
	endtask

	task automatic set_geometry(int unsigned w, int unsigned h);
		settle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	function automatic logic [15:0] gen_pixel(int base);
		int v;
		if ($urandom_range(99) < 8) begin
			case ($urandom_range(2))
				0: return 16'h0000;
				1: return 16'hFFFF;
				default: return 16'($urandom);
			endcase
		end
		v = base + $urandom_range(511) - 256;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return v[15:0];
	endfunction

	// rows_sent < h leaves the frame unfinished
	task automatic send_frame(int unsigned rows_sent, bit noisy);
		int base;
		int unsigned w;
		w = eff_w();
		base = $urandom_range(65535);
		for (int i = 0; i < w * rows_sent; i++) begin
			if (noisy && $urandom_range(99) < 3) send_item(16'($urandom), 1'b1);
			send_item(gen_pixel(base), 1'b0);
		end
		if (rows_sent >= eff_h())
			for (int i = 0; i < 2 * w + 2; i++)
				if (noisy && $urandom_range(99) < 15) send_item(16'($urandom), 1'b0);
				else send_item(16'($urandom), 1'b1);
	endtask

	task automatic test_small_frame();
		set_geometry(2, 2);
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b1);  // inside the frame, dropped
		send_item(16'hFFFF, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'h0000, 1'b1);
		send_item(16'h5555, 1'b1);
		send_item(16'hAAAA, 1'b0);  // past the last pixel, counts as drain
		send_item(16'h0000, 1'b1);
		send_item(16'h0000, 1'b1);
		send_item(16'h0000, 1'b1);
	endtask

	task automatic test_gain_extremes();
		settle();
		write_reg(REG_BRIGHT, 0);
		write_reg(REG_DARK, 4095);  // dark threshold above full scale for medians above 4097
		send_frame(2, 1'b0);
		settle();
		write_reg(REG_BRIGHT, 4095);
		write_reg(REG_DARK, 0);
		send_frame(2, 1'b0);
		settle();
		write_reg(REG_BRIGHT, 384);
		write_reg(REG_DARK, 192);
		write_reg(8'd7, 16'hFFFF);  // unmapped index
	endtask

	task automatic test_geometry_extremes();
		set_geometry(0, 0);
		send_frame(2, 1'b0);
		set_geometry(3, 3);
		send_frame(3, 1'b1);
		set_geometry(5, 7);
		send_frame(7, 1'b1);
		// width clamps to full line; far too few items for any result
		set_geometry(8191, 2);
		for (int i = 0; i < 40; i++) send_item(gen_pixel(4096), 1'b0);
		set_geometry(2, 16384);
		send_frame(20, 1'b0);
		set_geometry(2, 32767);
		send_frame(10, 1'b0);
	endtask

	task automatic test_backpressure();
		set_geometry(8, 8);
		hold_req <= 1'b1;
		send_frame(8, 1'b0);
		send_frame(8, 1'b0);
		hold_req <= 1'b0;
	endtask

	task automatic test_random_frames();
		int nf, h;
		nf = 0;
		while (items_sent < ITEM_TARGET) begin
			quiet = (nf % 7 == 3);
			set_geometry($urandom_range(13, 2), $urandom_range(9, 2));
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(3))
					0: write_reg(REG_BRIGHT, 0);
					1: write_reg(REG_BRIGHT, 4095);
					2: write_reg(REG_BRIGHT, $urandom_range(4095));
					default: write_reg(REG_BRIGHT, $urandom_range(512, 256));
				endcase
				case ($urandom_range(3))
					0: write_reg(REG_DARK, 0);
					1: write_reg(REG_DARK, 4095);
					2: write_reg(REG_DARK, $urandom_range(4095));
					default: write_reg(REG_DARK, $urandom_range(255, 128));
				endcase
			end
			h = eff_h();
			if ($urandom_range(9) == 0) send_frame($urandom_range(h - 1), 1'b1);
			else send_frame(h, $urandom_range(3) == 0);
			nf++;
		end
		quiet = 1'b0;
	endtask

	// result side: random stall, one long hold-off, compare in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected item: %p", res_data);
				end else begin
					if (res_data !== expected_pixels[0]) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p, got %p", expected_pixels[0], res_data);
					end
					void'(expected_pixels.pop_front());
				end
			end
			if (hold_req && !hold_armed) begin
				hold_armed <= 1'b1;
				hold_cnt <= HOLD_CYCLES;
			end else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
			res_stall <= (hold_cnt > 1) || (hold_req && !hold_armed) ||
				(!quiet && $urandom_range(99) < 38);
		end
	end

	always @(posedge clk) begin
		if ((px_valid && !px_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			watch <= 0;
		else watch <= watch + 1;
		if (watch >= WATCH_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_frame();
		test_gain_extremes();
		test_geometry_extremes();
		test_backpressure();
		test_random_frames();
		settle();
		errors += expected_pixels.size();
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
